>>> rtl/core/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types and constants for the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int BODY_W   = 24;  // max_body_size and body_count width
  localparam int LINE_W   = 8;   // max_size_line width
  localparam int CFG_W    = 24;  // config write data, widest register
  localparam int CFG_IDX_W = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHUNKED_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE_LINE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_BIG   = 2'd3;

  // characters
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_EXT = 8'd59;  // ';'

  typedef struct packed {
    logic              chunked_mode;
    logic [BODY_W-1:0] max_body_size;
    logic [LINE_W-1:0] max_size_line;
  } cfg_t;

  typedef struct packed {
    logic              out_valid;
    logic [7:0]        out_byte;
    logic [1:0]        status;
    logic              complete;
    logic [BODY_W-1:0] body_count;
  } res_t;

endpackage

>>> rtl/core/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// byte-wide decoder for plain and chunked http/1.1 request bodies
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_ready   data_byte
//  result    res_valid / res_ready out_valid, out_byte, status, complete,
//                                  body_count
//  config    wr_en                 wr_index, wr_data
//
//  one item per cycle sustained while results are taken; each item passes
//  the input register, then the state update feeding the result register
//  the decoder state advances when an item moves from the input register
//  into the result register, so a stalled result holds the whole pipe
//  rst is synchronous, resets state and config and clears both valid flags
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int SIZE_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic [1:0]           status,
  output logic                 complete,
  output logic [BODY_W-1:0]    body_count
);

  cfg_t       cfg;
  res_t       step_res;
  res_t       res_reg;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;

  // item moves on when the result slot is free or being emptied
  assign advance  = hold_valid && (!res_valid || res_ready);
  assign in_ready = !hold_valid || advance;

  hcbd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  hcbd_step #(
    .COUNT_BITS (COUNT_BITS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .data_byte (hold_byte),
    .cfg       (cfg),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (in_ready) hold_valid <= in_valid;
      if (advance) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
    if (in_valid && in_ready) hold_byte <= data_byte;
    if (advance) res_reg <= step_res;
  end

  assign out_valid  = res_reg.out_valid;
  assign out_byte   = res_reg.out_byte;
  assign status     = res_reg.status;
  assign complete   = res_reg.complete;
  assign body_count = res_reg.body_count;

endmodule

>>> rtl/core/hcbd_cfg.sv
// ----------------------------------------------------------------------------
// hcbd_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module hcbd_cfg
  import hcbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunked_mode  <= 1'b0;
      cfg.max_body_size <= BODY_W'(1048576);
      cfg.max_size_line <= LINE_W'(64);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CHUNKED_MODE:  cfg.chunked_mode  <= wr_data[0];
        REG_MAX_BODY_SIZE: cfg.max_body_size <= wr_data[BODY_W-1:0];
        REG_MAX_SIZE_LINE: cfg.max_size_line <= wr_data[LINE_W-1:0];
        default: ;  // unused index
      endcase
    end
  end

endmodule

>>> rtl/core/hcbd_step.sv
// ----------------------------------------------------------------------------
// hcbd_step
// decoder state and the per-byte update, one item per fire
// ----------------------------------------------------------------------------
module hcbd_step
  import hcbd_pkg::*;
#(
  parameter int COUNT_BITS = 24,
  parameter int SIZE_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  localparam int MAX_CS   = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;
  localparam int MAX_ALL  = (MAX_CS > BODY_W) ? MAX_CS : BODY_W;
  localparam int SUM_BITS = MAX_ALL + 1;

  typedef enum logic [2:0] {
    PH_HEX     = 3'd0,
    PH_EXT     = 3'd1,
    PH_HEX_CR  = 3'd2,
    PH_EXT_CR  = 3'd3,
    PH_DATA    = 3'd4,
    PH_WANT_CR = 3'd5,
    PH_WANT_LF = 3'd6,
    PH_TRAILER = 3'd7
  } phase_t;

  // bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'd48 && b <= 8'd57)       r = {1'b1, 4'(b - 8'd48)};
    else if (b >= 8'd65 && b <= 8'd70)  r = {1'b1, 4'(b - 8'd55)};
    else if (b >= 8'd97 && b <= 8'd102) r = {1'b1, 4'(b - 8'd87)};
    return r;
  endfunction

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  chunk_length, chunk_length_next;
  logic [SIZE_BITS-1:0]  data_left, data_left_next;
  logic [LINE_W-1:0]     line_length, line_length_next;
  logic [COUNT_BITS-1:0] accepted_count, accepted_count_next;
  logic [1:0]            end_match, end_match_next;
  logic                  saw_digit, saw_digit_next;
  logic [1:0]            sticky_status, sticky_status_next;
  logic                  done_flag, done_flag_next;

  logic                  closes;
  logic [4:0]            hex;
  logic [SUM_BITS-1:0]   size_sum;
  logic                  ob_valid;

  assign hex      = hex_digit(data_byte);
  assign closes   = (phase == PH_HEX_CR || phase == PH_EXT_CR) && data_byte == CH_LF;
  assign size_sum = SUM_BITS'(accepted_count) + SUM_BITS'(chunk_length);

  always_comb begin
    phase_next          = phase;
    chunk_length_next   = chunk_length;
    data_left_next      = data_left;
    line_length_next    = line_length;
    accepted_count_next = accepted_count;
    end_match_next      = end_match;
    saw_digit_next      = saw_digit;
    sticky_status_next  = sticky_status;
    done_flag_next      = done_flag;
    ob_valid            = 1'b0;

    if (sticky_status == ST_OK) begin
      if (!cfg.chunked_mode) begin
        if (SUM_BITS'(accepted_count) < SUM_BITS'(cfg.max_body_size)) begin
          ob_valid            = 1'b1;
          accepted_count_next = accepted_count + COUNT_BITS'(1);
        end else begin
          sticky_status_next = ST_TRUNC;
        end
      end else if (phase == PH_HEX || phase == PH_EXT ||
                   phase == PH_HEX_CR || phase == PH_EXT_CR) begin
        if (!closes && line_length >= cfg.max_size_line) begin
          sticky_status_next = ST_BAD;
        end else if (closes) begin
          // end of the size line
          if (!saw_digit) begin
            sticky_status_next = ST_BAD;
          end else if (chunk_length == '0) begin
            phase_next     = PH_TRAILER;
            end_match_next = 2'd2;  // line CRLF is the first half of CRLFCRLF
          end else if (size_sum > SUM_BITS'(cfg.max_body_size)) begin
            sticky_status_next = ST_BIG;
          end else begin
            data_left_next = chunk_length;
            phase_next     = PH_DATA;
          end
        end else begin
          line_length_next = line_length + LINE_W'(1);
          if (phase == PH_HEX_CR) begin
            sticky_status_next = ST_BAD;
          end else if (phase == PH_EXT || phase == PH_EXT_CR) begin
            phase_next = (data_byte == CH_CR) ? PH_EXT_CR : PH_EXT;
          end else if (data_byte == CH_CR) begin
            phase_next = PH_HEX_CR;
          end else if (data_byte == CH_EXT) begin
            if (!saw_digit) sticky_status_next = ST_BAD;
            else            phase_next = PH_EXT;
          end else if (!hex[4] || chunk_length[SIZE_BITS-1 -: 4] != 4'd0) begin
            sticky_status_next = ST_BAD;
          end else begin
            chunk_length_next = {chunk_length[SIZE_BITS-5:0], hex[3:0]};
            saw_digit_next    = 1'b1;
          end
        end
      end else begin
        unique case (phase)
          PH_DATA: begin
            ob_valid            = 1'b1;
            accepted_count_next = accepted_count + COUNT_BITS'(1);
            data_left_next      = data_left - SIZE_BITS'(1);
            if (data_left == SIZE_BITS'(1)) phase_next = PH_WANT_CR;
          end
          PH_WANT_CR: begin
            if (data_byte == CH_CR) phase_next = PH_WANT_LF;
            else                    sticky_status_next = ST_BAD;
          end
          PH_WANT_LF: begin
            if (data_byte == CH_LF) begin
              phase_next        = PH_HEX;
              chunk_length_next = '0;
              line_length_next  = '0;
              saw_digit_next    = 1'b0;
            end else begin
              sticky_status_next = ST_BAD;
            end
          end
          default: begin
            // trailer: look for CRLFCRLF only
            if (!done_flag) begin
              if (data_byte == CH_CR)
                end_match_next = (end_match == 2'd2) ? 2'd3 : 2'd1;
              else if (data_byte == CH_LF && end_match == 2'd1)
                end_match_next = 2'd2;
              else if (data_byte == CH_LF && end_match == 2'd3)
                done_flag_next = 1'b1;
              else
                end_match_next = 2'd0;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    res.out_valid  = ob_valid;
    res.out_byte   = ob_valid ? data_byte : 8'd0;
    res.status     = sticky_status_next;
    res.complete   = done_flag_next;
    res.body_count = BODY_W'(accepted_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEX;
      chunk_length   <= '0;
      data_left      <= '0;
      line_length    <= '0;
      accepted_count <= '0;
      end_match      <= 2'd0;
      saw_digit      <= 1'b0;
      sticky_status  <= ST_OK;
      done_flag      <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      chunk_length   <= chunk_length_next;
      data_left      <= data_left_next;
      line_length    <= line_length_next;
      accepted_count <= accepted_count_next;
      end_match      <= end_match_next;
      saw_digit      <= saw_digit_next;
      sticky_status  <= sticky_status_next;
      done_flag      <= done_flag_next;
    end
  end

endmodule
